/* hw/rtl/nrrb_pkg.sv */
// ----------------------------------------------------------------------------
// nrrb_pkg
// Shared types, constants and codes of the round-robin NAT balancer.
// ----------------------------------------------------------------------------
package nrrb_pkg;

	// default sizes
	localparam int unsigned FLOW_ENTRIES_DEF = 64;
	localparam int unsigned SERVER_COUNT_DEF = 4;
	localparam int unsigned SERVER_REGS      = 4;
	localparam int unsigned SRV_W            = 2;
	localparam int unsigned QUEUE_DEPTH      = 2;

	// configuration port geometry
	localparam int unsigned APB_ADDR_W  = 5;
	localparam int unsigned APB_DATA_W  = 32;
	localparam int unsigned REG_IDX_LSB = 2;

	typedef logic [31:0] addr_t;
	typedef logic [15:0] port_t;

	// protocol and direction codes
	localparam logic [7:0] UDP_PROTO   = 8'd17;
	localparam logic       OP_INBOUND  = 1'b0;
	localparam logic       OP_OUTBOUND = 1'b1;

	// verdict codes
	localparam logic [1:0] VERDICT_ACCEPT  = 2'd0;
	localparam logic [1:0] VERDICT_REWRITE = 2'd1;
	localparam logic [1:0] VERDICT_DROP    = 2'd2;

	// register reset values
	localparam addr_t PUBLIC_ADDRESS_RST = 32'h9898_0015;
	localparam port_t PUBLIC_PORT_RST    = 16'h1F90;
	localparam addr_t SERVER_ADDR_0_RST  = 32'hC0A8_0101;
	localparam addr_t SERVER_ADDR_1_RST  = 32'hC0A8_0201;
	localparam addr_t SERVER_ADDR_2_RST  = 32'hC0A8_0301;
	localparam addr_t SERVER_ADDR_3_RST  = 32'hC0A8_0401;

	// register map indexes
	typedef enum logic [2:0] {
		REG_PUBLIC_ADDRESS = 3'd0,
		REG_PUBLIC_PORT    = 3'd1,
		REG_SERVER_ADDR_0  = 3'd2,
		REG_SERVER_ADDR_1  = 3'd3,
		REG_SERVER_ADDR_2  = 3'd4,
		REG_SERVER_ADDR_3  = 3'd5
	} cfg_reg_t;

	// packet header transaction
	typedef struct packed {
		logic       op;
		logic       on_client_side;
		addr_t      src_addr;
		addr_t      dst_addr;
		logic [7:0] protocol;
		port_t      src_port;
		port_t      dst_port;
	} pkt_t;

	// verdict transaction
	typedef struct packed {
		logic [1:0] verdict;
		addr_t      new_addr;
		logic       flow_created;
	} res_t;

	// live configuration
	typedef struct packed {
		addr_t                        public_address;
		port_t                        public_port;
		logic [SERVER_REGS-1:0][31:0] server_addr;
	} cfg_t;

	// classified work handed from front to back
	typedef enum logic [1:0] {
		CMD_ACCEPT,
		CMD_DROP,
		CMD_LOOKUP_IN,
		CMD_LOOKUP_OUT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		addr_t     key_addr;
		port_t     key_port;
	} cmd_t;

	// queue status toward the back end
	typedef struct packed {
		logic vld;
		cmd_t cmd;
	} queue_head_t;

	// one flow table entry
	typedef struct packed {
		addr_t client_addr;
		port_t cli_port;
		addr_t server_addr;
	} flow_entry_t;

	typedef enum logic {
		BE_IDLE,
		BE_SEARCH
	} be_state_t;

endpackage

/* hw/rtl/nrrb_stream_if.sv */
// ----------------------------------------------------------------------------
// nrrb_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface nrrb_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/nrrb_front.sv */
// ----------------------------------------------------------------------------
// nrrb_front
// Accepts packet headers and classifies them into immediate verdicts or
// flow table lookups.
// ----------------------------------------------------------------------------
module nrrb_front (
	nrrb_stream_if.sink    pkt,
	input  nrrb_pkg::cfg_t cfg,
	input  logic           q_ready,
	output logic           push,
	output nrrb_pkg::cmd_t push_cmd
);

	nrrb_pkg::pkt_t hdr;

	assign hdr      = pkt.data;
	assign pkt.ready = q_ready;
	assign push     = pkt.valid && q_ready;

	// header checks in priority order
	always_comb begin
		push_cmd.kind     = nrrb_pkg::CMD_ACCEPT;
		push_cmd.key_addr = hdr.src_addr;
		push_cmd.key_port = hdr.src_port;
		if (hdr.op == nrrb_pkg::OP_INBOUND) begin
			if (!hdr.on_client_side || hdr.dst_addr == '0) begin
				push_cmd.kind = nrrb_pkg::CMD_ACCEPT;
			end else if (hdr.dst_addr != cfg.public_address) begin
				push_cmd.kind = nrrb_pkg::CMD_DROP;
			end else if (hdr.protocol != nrrb_pkg::UDP_PROTO) begin
				push_cmd.kind = nrrb_pkg::CMD_ACCEPT;
			end else if (hdr.dst_port != cfg.public_port) begin
				push_cmd.kind = nrrb_pkg::CMD_DROP;
			end else begin
				push_cmd.kind = nrrb_pkg::CMD_LOOKUP_IN;
			end
		end else begin
			// outbound traffic is keyed by its client destination
			push_cmd.key_addr = hdr.dst_addr;
			push_cmd.key_port = hdr.dst_port;
			if (!hdr.on_client_side || hdr.protocol != nrrb_pkg::UDP_PROTO) begin
				push_cmd.kind = nrrb_pkg::CMD_ACCEPT;
			end else begin
				push_cmd.kind = nrrb_pkg::CMD_LOOKUP_OUT;
			end
		end
	end

endmodule

/* hw/rtl/nrrb_cmd_queue.sv */
// ----------------------------------------------------------------------------
// nrrb_cmd_queue
// Short FIFO of classified commands between front and back end.
// ----------------------------------------------------------------------------
module nrrb_cmd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  nrrb_pkg::cmd_t        push_cmd,
	output logic                  ready,
	input  logic                  pop,
	output nrrb_pkg::queue_head_t head
);

	localparam int unsigned DEPTH = nrrb_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	nrrb_pkg::cmd_t   slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign ready    = cnt_q != CNT_W'(DEPTH);
	assign head.vld = cnt_q != '0;
	assign head.cmd = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* hw/rtl/nrrb_back.sv */
// ----------------------------------------------------------------------------
// nrrb_back
// Executes commands: walks the flow table, inserts new flows round-robin
// and holds the verdict in an output register.
// ----------------------------------------------------------------------------
module nrrb_back #(
	parameter int unsigned FLOW_ENTRIES = nrrb_pkg::FLOW_ENTRIES_DEF,
	parameter int unsigned SERVER_COUNT = nrrb_pkg::SERVER_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nrrb_pkg::cfg_t        cfg,
	input  nrrb_pkg::queue_head_t head,
	output logic                  pop,
	nrrb_stream_if.source         res
);

	localparam int unsigned IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(FLOW_ENTRIES + 1);
	localparam int unsigned SRV_W = nrrb_pkg::SRV_W;

	nrrb_pkg::be_state_t   state_q;
	nrrb_pkg::be_state_t   state_d;
	nrrb_pkg::cmd_t        cmd_q;
	nrrb_pkg::res_t        res_q;
	nrrb_pkg::res_t        res_d;
	logic                  res_vld_q;
	nrrb_pkg::flow_entry_t flow_mem_q [FLOW_ENTRIES];
	nrrb_pkg::flow_entry_t rd_data_s1;
	nrrb_pkg::flow_entry_t new_entry;
	logic                  probe_s1;
	logic [CNT_W-1:0]      rd_idx_q;
	logic [CNT_W-1:0]      count_q;
	logic [SRV_W-1:0]      ptr_q;
	nrrb_pkg::addr_t       sel_server;
	logic                  out_free;
	logic                  more;
	logic                  hit;
	logic                  full;
	logic                  start;
	logic                  issue;
	logic                  load_res;
	logic                  mem_we;

	assign res.valid = res_vld_q;
	assign res.data  = res_q;

	assign out_free   = !res_vld_q || res.ready;
	assign more       = rd_idx_q != count_q;
	assign full       = count_q == CNT_W'(FLOW_ENTRIES);
	assign hit        = probe_s1 && rd_data_s1.client_addr == cmd_q.key_addr
		&& rd_data_s1.cli_port == cmd_q.key_port;
	assign sel_server = cfg.server_addr[ptr_q];

	assign new_entry.client_addr = cmd_q.key_addr;
	assign new_entry.cli_port    = cmd_q.key_port;
	assign new_entry.server_addr = sel_server;

	// next state and datapath controls
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		start    = 1'b0;
		issue    = 1'b0;
		load_res = 1'b0;
		mem_we   = 1'b0;
		res_d    = '0;
		case (state_q)
			nrrb_pkg::BE_IDLE: begin
				if (head.vld && out_free) begin
					pop = 1'b1;
					case (head.cmd.kind)
						nrrb_pkg::CMD_ACCEPT: begin
							load_res      = 1'b1;
							res_d.verdict = nrrb_pkg::VERDICT_ACCEPT;
						end
						nrrb_pkg::CMD_DROP: begin
							load_res      = 1'b1;
							res_d.verdict = nrrb_pkg::VERDICT_DROP;
						end
						default: begin
							start   = 1'b1;
							state_d = nrrb_pkg::BE_SEARCH;
						end
					endcase
				end
			end
			nrrb_pkg::BE_SEARCH: begin
				issue = more && !hit;
				if (hit) begin
					load_res      = 1'b1;
					state_d       = nrrb_pkg::BE_IDLE;
					res_d.verdict = nrrb_pkg::VERDICT_REWRITE;
					res_d.new_addr = (cmd_q.kind == nrrb_pkg::CMD_LOOKUP_IN)
						? rd_data_s1.server_addr : cfg.public_address;
				end else if (!more) begin
					// every stored flow checked without a match
					load_res = 1'b1;
					state_d  = nrrb_pkg::BE_IDLE;
					if (cmd_q.kind == nrrb_pkg::CMD_LOOKUP_OUT || full) begin
						res_d.verdict = nrrb_pkg::VERDICT_DROP;
					end else begin
						mem_we             = 1'b1;
						res_d.verdict      = nrrb_pkg::VERDICT_REWRITE;
						res_d.new_addr     = sel_server;
						res_d.flow_created = 1'b1;
					end
				end
			end
			default: begin
				state_d = nrrb_pkg::BE_IDLE;
			end
		endcase
	end

	// flow table memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			flow_mem_q[count_q[IDX_W-1:0]] <= new_entry;
		end
		rd_data_s1 <= flow_mem_q[rd_idx_q[IDX_W-1:0]];
	end

	// command and result payload
	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q <= head.cmd;
		end
		if (load_res) begin
			res_q <= res_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= nrrb_pkg::BE_IDLE;
			res_vld_q <= 1'b0;
			rd_idx_q  <= '0;
			probe_s1  <= 1'b0;
			count_q   <= '0;
			ptr_q     <= '0;
		end else begin
			state_q  <= state_d;
			probe_s1 <= issue;
			if (load_res) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
			if (start) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (mem_we) begin
				count_q <= count_q + CNT_W'(1);
				ptr_q   <= (ptr_q == SRV_W'(SERVER_COUNT - 1)) ? '0 : ptr_q + SRV_W'(1);
			end
		end
	end

endmodule

/* hw/rtl/nat_round_robin_balancer_unit.sv */
// ----------------------------------------------------------------------------
// nat_round_robin_balancer_unit
// UDP destination NAT with a flow table and round-robin server choice.
// ----------------------------------------------------------------------------
// Each packet header yields one verdict. Headers that need no flow lookup
// (wrong side, zero or wrong address, wrong port, not UDP) pass the two-entry
// command queue and take their verdict straight from the back end. A lookup
// walks the stored flows in slot order through the single read port of the
// flow table; an inbound miss inserts a new flow once every stored flow has
// been checked. The table starts empty after reset, with no clearing pass;
// flows are never removed, and once FLOW_ENTRIES flows are stored new inbound
// clients are dropped. Configuration must be written over the APB port only
// while no packet is in flight; the block itself does not enforce this.
module nat_round_robin_balancer_unit #(
	parameter int unsigned FLOW_ENTRIES = nrrb_pkg::FLOW_ENTRIES_DEF,
	parameter int unsigned SERVER_COUNT = nrrb_pkg::SERVER_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	nrrb_stream_if.sink                     pkt,
	nrrb_stream_if.source                   res,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [nrrb_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [nrrb_pkg::APB_DATA_W-1:0] pwdata,
	output logic [nrrb_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	nrrb_pkg::cfg_t        cfg_q;
	nrrb_pkg::cfg_reg_t    reg_idx;
	nrrb_pkg::cmd_t        push_cmd;
	nrrb_pkg::queue_head_t head;
	logic                  push;
	logic                  q_ready;
	logic                  pop;
	logic                  cfg_wr;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = nrrb_pkg::cfg_reg_t'(paddr[nrrb_pkg::APB_ADDR_W-1:nrrb_pkg::REG_IDX_LSB]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.public_address <= nrrb_pkg::PUBLIC_ADDRESS_RST;
			cfg_q.public_port    <= nrrb_pkg::PUBLIC_PORT_RST;
			cfg_q.server_addr[0] <= nrrb_pkg::SERVER_ADDR_0_RST;
			cfg_q.server_addr[1] <= nrrb_pkg::SERVER_ADDR_1_RST;
			cfg_q.server_addr[2] <= nrrb_pkg::SERVER_ADDR_2_RST;
			cfg_q.server_addr[3] <= nrrb_pkg::SERVER_ADDR_3_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				nrrb_pkg::REG_PUBLIC_ADDRESS: cfg_q.public_address <= pwdata;
				nrrb_pkg::REG_PUBLIC_PORT:    cfg_q.public_port    <= pwdata[15:0];
				nrrb_pkg::REG_SERVER_ADDR_0:  cfg_q.server_addr[0] <= pwdata;
				nrrb_pkg::REG_SERVER_ADDR_1:  cfg_q.server_addr[1] <= pwdata;
				nrrb_pkg::REG_SERVER_ADDR_2:  cfg_q.server_addr[2] <= pwdata;
				nrrb_pkg::REG_SERVER_ADDR_3:  cfg_q.server_addr[3] <= pwdata;
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			nrrb_pkg::REG_PUBLIC_ADDRESS: prdata = cfg_q.public_address;
			nrrb_pkg::REG_PUBLIC_PORT:    prdata = {16'h0000, cfg_q.public_port};
			nrrb_pkg::REG_SERVER_ADDR_0:  prdata = cfg_q.server_addr[0];
			nrrb_pkg::REG_SERVER_ADDR_1:  prdata = cfg_q.server_addr[1];
			nrrb_pkg::REG_SERVER_ADDR_2:  prdata = cfg_q.server_addr[2];
			nrrb_pkg::REG_SERVER_ADDR_3:  prdata = cfg_q.server_addr[3];
			default:                      prdata = '0;
		endcase
	end

	// header classification
	nrrb_front u_front (
		.pkt      (pkt),
		.cfg      (cfg_q),
		.q_ready  (q_ready),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// decoupling queue
	nrrb_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.ready    (q_ready),
		.pop      (pop),
		.head     (head)
	);

	// flow table and verdicts
	nrrb_back #(
		.FLOW_ENTRIES (FLOW_ENTRIES),
		.SERVER_COUNT (SERVER_COUNT)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.pop    (pop),
		.res    (res)
	);

endmodule
